### rtl/core/frame_deframer_fnv_check_core_defines.svh
// Assertion macros used by the deframer top level.
`ifndef FRAME_DEFRAMER_FNV_CHECK_CORE_DEFINES_SVH
`define FRAME_DEFRAMER_FNV_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define FDFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked on i_clk outside reset.
`define FDFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### rtl/core/fdfc_pkg.sv
// Shared types, codes and the FNV-1a 64 step for the frame deframer.
`default_nettype none

package fdfc_pkg;

    localparam int HDR_BYTES = 12;
    localparam int DIG_BYTES = 8;
    localparam int POS_W     = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [POS_W-1:0] HASH_START   = POS_W'(4);
    localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HDR_BYTES - 1);
    localparam logic [POS_W-1:0] LAST_DIG_POS = POS_W'(DIG_BYTES - 1);

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_GOOD    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MALFORMED = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_OVERSIZE  = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAXTYPE = 2'd2;
    localparam logic [1:0] CFG_MAXLEN  = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DIGEST
    } t_phase;

    // Work classes handed from front to back
    typedef enum logic [2:0] {
        OP_SKIP,
        OP_HASH,
        OP_HDR_OK,
        OP_ERROR,
        OP_PAYLOAD,
        OP_DIGEST,
        OP_DIGEST_END
    } t_op;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  max_type;
        logic [31:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [7:0]  msg_type;
        logic [7:0]  flags;
        logic [31:0] len;
    } t_q_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One FNV-1a step; the prime is 2^40 + 0x1b3, so shifts and adds suffice.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fdfc_front.sv
// Front end: tracks frame position, stores the header, checks it and classifies each byte.
`default_nettype none

module fdfc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_data,
    input  wire fdfc_pkg::t_cfg   i_cfg,
    output fdfc_pkg::t_q_item     o_item,
    output logic                  o_valid
);

    fdfc_pkg::t_phase           r_phase, n_phase;
    logic [fdfc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [31:0]                r_rem, n_rem;
    logic [7:0]                 r_hdr [0:fdfc_pkg::HDR_BYTES-1];

    logic [31:0] w_magic;
    logic [31:0] w_live_len;
    logic [31:0] w_stored_len;
    logic [2:0]  w_err;

    assign w_magic      = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_live_len   = {i_data, r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_stored_len = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};

    // Header checks in priority order: magic, version, type bound, length bound
    always_comb begin
        if (w_magic != i_cfg.magic) begin
            w_err = fdfc_pkg::ERR_MALFORMED;
        end else if (r_hdr[4] != i_cfg.version) begin
            w_err = fdfc_pkg::ERR_VERSION;
        end else if (r_hdr[5] > i_cfg.max_type) begin
            w_err = fdfc_pkg::ERR_MALFORMED;
        end else if (w_live_len > i_cfg.max_len) begin
            w_err = fdfc_pkg::ERR_OVERSIZE;
        end else begin
            w_err = fdfc_pkg::ERR_NONE;
        end
    end

    // Hold the header bytes as they arrive
    always_ff @(posedge i_clk) begin
        if (i_valid && r_phase == fdfc_pkg::PH_HEADER) begin
            r_hdr[r_pos] <= i_data;
        end
    end

    // Advance the frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fdfc_pkg::PH_HEADER;
            r_pos   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
    end

    // Classify the byte and pick the next position
    always_comb begin
        n_phase         = r_phase;
        n_pos           = r_pos;
        n_rem           = r_rem;
        o_item.op       = fdfc_pkg::OP_SKIP;
        o_item.data     = i_data;
        o_item.err      = fdfc_pkg::ERR_NONE;
        o_item.msg_type = r_hdr[5];
        o_item.flags    = r_hdr[6];
        o_item.len      = w_stored_len;
        if (i_valid) begin
            case (r_phase)
                fdfc_pkg::PH_HEADER: begin
                    o_item.op = (r_pos >= fdfc_pkg::HASH_START) ? fdfc_pkg::OP_HASH
                                                                : fdfc_pkg::OP_SKIP;
                    if (r_pos == fdfc_pkg::LAST_HDR_POS) begin
                        o_item.len = w_live_len;
                        n_pos      = '0;
                        if (w_err != fdfc_pkg::ERR_NONE) begin
                            o_item.op  = fdfc_pkg::OP_ERROR;
                            o_item.err = w_err;
                        end else begin
                            o_item.op = fdfc_pkg::OP_HDR_OK;
                            n_rem     = w_live_len;
                            n_phase   = (w_live_len == 32'd0) ? fdfc_pkg::PH_DIGEST
                                                              : fdfc_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                fdfc_pkg::PH_PAYLOAD: begin
                    o_item.op = fdfc_pkg::OP_PAYLOAD;
                    n_rem     = r_rem - 32'd1;
                    if (r_rem == 32'd1) begin
                        n_phase = fdfc_pkg::PH_DIGEST;
                        n_pos   = '0;
                    end
                end
                fdfc_pkg::PH_DIGEST: begin
                    if (r_pos == fdfc_pkg::LAST_DIG_POS) begin
                        o_item.op = fdfc_pkg::OP_DIGEST_END;
                        n_phase   = fdfc_pkg::PH_HEADER;
                        n_pos     = '0;
                    end else begin
                        o_item.op = fdfc_pkg::OP_DIGEST;
                        n_pos     = r_pos + 1'b1;
                    end
                end
                default: begin
                    n_phase = fdfc_pkg::PH_HEADER;
                    n_pos   = '0;
                end
            endcase
        end
    end

    assign o_valid = i_valid;

endmodule

`default_nettype wire

### rtl/core/fdfc_queue.sv
// Short queue of classified items between front and back.
`default_nettype none

module fdfc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire fdfc_pkg::t_q_item i_item,
    input  wire logic              i_pop,
    output fdfc_pkg::t_q_item      o_item,
    output fdfc_pkg::t_q_status    o_status
);

    fdfc_pkg::t_q_item            r_mem [0:fdfc_pkg::Q_DEPTH-1];
    logic [fdfc_pkg::Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [fdfc_pkg::Q_CNT_W-1:0] r_count;
    logic                         w_do_push, w_do_pop;

    assign o_status.full  = (r_count == fdfc_pkg::Q_CNT_W'(fdfc_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item = r_mem[r_rptr];

endmodule

`default_nettype wire

### rtl/core/fdfc_back.sv
// Back end: runs the FNV-1a hash, collects the digest and registers each result item.
`default_nettype none

module fdfc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fdfc_pkg::t_q_item  i_item,
    input  wire fdfc_pkg::t_q_status i_q_status,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_byte_out,
    output logic [7:0]              o_msg_type,
    output logic [7:0]              o_frame_flags,
    output logic [31:0]             o_payload_len,
    output logic [2:0]              o_error_code,
    output logic                    o_last_of_frame
);

    logic [63:0] r_hash, n_hash;
    logic [63:0] r_digest, n_digest;
    logic        r_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_type;
    logic [7:0]  r_flags;
    logic [31:0] r_len;
    logic [2:0]  r_err, n_err;
    logic        r_last, n_last;
    logic        w_emits;
    logic        w_slot_free;
    logic [63:0] w_digest_full;

    assign w_digest_full = {i_item.data, r_digest[63:8]};
    assign w_slot_free   = !r_valid || i_pop;

    // Decide whether the item makes a result and what it is
    always_comb begin
        w_emits  = 1'b0;
        n_hash   = r_hash;
        n_digest = r_digest;
        n_kind   = fdfc_pkg::KIND_HEADER;
        n_byte   = 8'd0;
        n_err    = fdfc_pkg::ERR_NONE;
        n_last   = 1'b0;
        case (i_item.op)
            fdfc_pkg::OP_SKIP: begin
                n_hash = r_hash;
            end
            fdfc_pkg::OP_HASH: begin
                n_hash = fdfc_pkg::fnv_step(r_hash, i_item.data);
            end
            fdfc_pkg::OP_HDR_OK: begin
                w_emits  = 1'b1;
                n_hash   = fdfc_pkg::fnv_step(r_hash, i_item.data);
                n_digest = '0;
            end
            fdfc_pkg::OP_ERROR: begin
                w_emits  = 1'b1;
                n_hash   = fdfc_pkg::FNV_BASIS;
                n_digest = '0;
                n_kind   = fdfc_pkg::KIND_ERROR;
                n_err    = i_item.err;
                n_last   = 1'b1;
            end
            fdfc_pkg::OP_PAYLOAD: begin
                w_emits = 1'b1;
                n_hash  = fdfc_pkg::fnv_step(r_hash, i_item.data);
                n_kind  = fdfc_pkg::KIND_PAYLOAD;
                n_byte  = i_item.data;
            end
            fdfc_pkg::OP_DIGEST: begin
                n_digest = w_digest_full;
            end
            fdfc_pkg::OP_DIGEST_END: begin
                w_emits  = 1'b1;
                n_hash   = fdfc_pkg::FNV_BASIS;
                n_digest = '0;
                n_last   = 1'b1;
                if (w_digest_full == r_hash) begin
                    n_kind = fdfc_pkg::KIND_GOOD;
                end else begin
                    n_kind = fdfc_pkg::KIND_ERROR;
                    n_err  = fdfc_pkg::ERR_CHECKSUM;
                end
            end
            default: begin
                n_hash = r_hash;
            end
        endcase
    end

    // Take an item when the queue holds one and its result, if any, has a place to go
    assign o_q_pop = !i_q_status.empty && (!w_emits || w_slot_free);

    // Update hash and digest state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= fdfc_pkg::FNV_BASIS;
            r_digest <= '0;
        end else if (o_q_pop) begin
            r_hash   <= n_hash;
            r_digest <= n_digest;
        end
    end

    // Track whether the output register holds a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop && w_emits) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result fields
    always_ff @(posedge i_clk) begin
        if (o_q_pop && w_emits) begin
            r_kind  <= n_kind;
            r_byte  <= n_byte;
            r_type  <= i_item.msg_type;
            r_flags <= i_item.flags;
            r_len   <= i_item.len;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_byte_out      = r_byte;
    assign o_msg_type      = r_type;
    assign o_frame_flags   = r_flags;
    assign o_payload_len   = r_len;
    assign o_error_code    = r_err;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

### rtl/core/frame_deframer_fnv_check_core.sv
// Top level of the length-prefixed frame deframer with FNV-1a 64 check.
//
// Input channel: one frame byte per item on i_data_byte, taken at a clock edge with
// i_push high and o_full low. A frame is a 12-byte header (magic, version, type,
// flags, reserved, length, little endian), the payload and an 8-byte digest.
// Result channel: while o_empty is low the oldest result sits on the o_ ports and
// leaves at an edge with i_pop high. Kinds: header accepted, payload byte,
// frame good, error (with o_error_code, o_last_of_frame set on frame ends).
// Each result passes through the queue and is registered in the back end.
// One byte per cycle is sustained while results are popped; the rate is set by
// the hash unit in the back end, which does one FNV multiply by the constant prime
// per byte. A four-entry queue separates the classifying front end from the back
// end, so bytes keep flowing while a result waits; when the receiver stalls, the
// queue fills and o_full rises until results are popped again.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) takes effect at once; write it
// only while the block is idle. After an error the next byte starts a new header.
// Reset (synchronous, active low) loads register defaults, clears the queue and
// output, and restarts header hunting with a fresh hash; no clearing pass.
`default_nettype none
`include "frame_deframer_fnv_check_core_defines.svh"

module frame_deframer_fnv_check_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_out,
    output logic [7:0]       o_msg_type,
    output logic [7:0]       o_frame_flags,
    output logic [31:0]      o_payload_len,
    output logic [2:0]       o_error_code,
    output logic             o_last_of_frame,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    fdfc_pkg::t_cfg      r_cfg;
    fdfc_pkg::t_q_item   w_front_item;
    fdfc_pkg::t_q_item   w_q_item;
    fdfc_pkg::t_q_status w_q_status;
    logic                w_front_valid;
    logic                w_q_pop;
    logic                w_out_valid;
    logic                w_accept;
    logic                w_err_shown;
    logic                w_err_closed;
    logic                w_mid_shown;
    logic                w_mid_clean;
    logic                w_held;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic    <= 32'd0;
            r_cfg.version  <= 8'd1;
            r_cfg.max_type <= 8'd7;
            r_cfg.max_len  <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fdfc_pkg::CFG_MAGIC:   r_cfg.magic    <= i_cfg_data;
                fdfc_pkg::CFG_VERSION: r_cfg.version  <= i_cfg_data[7:0];
                fdfc_pkg::CFG_MAXTYPE: r_cfg.max_type <= i_cfg_data[7:0];
                fdfc_pkg::CFG_MAXLEN:  r_cfg.max_len  <= i_cfg_data;
                default:               r_cfg          <= r_cfg;
            endcase
        end
    end

    assign o_full   = w_q_status.full;
    assign w_accept = i_push && !w_q_status.full;

    fdfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (i_data_byte),
        .i_cfg   (r_cfg),
        .o_item  (w_front_item),
        .o_valid (w_front_valid)
    );

    fdfc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front_valid),
        .i_item   (w_front_item),
        .i_pop    (w_q_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    fdfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_q_item),
        .i_q_status      (w_q_status),
        .o_q_pop         (w_q_pop),
        .i_pop           (i_pop),
        .o_valid         (w_out_valid),
        .o_kind          (o_kind),
        .o_byte_out      (o_byte_out),
        .o_msg_type      (o_msg_type),
        .o_frame_flags   (o_frame_flags),
        .o_payload_len   (o_payload_len),
        .o_error_code    (o_error_code),
        .o_last_of_frame (o_last_of_frame)
    );

    assign o_empty = !w_out_valid;

    // Terms used by the checks below
    assign w_err_shown  = !o_empty && o_kind == fdfc_pkg::KIND_ERROR;
    assign w_err_closed = o_last_of_frame && o_error_code != fdfc_pkg::ERR_NONE;
    assign w_mid_shown  = !o_empty && (o_kind == fdfc_pkg::KIND_PAYLOAD ||
                                       o_kind == fdfc_pkg::KIND_HEADER);
    assign w_mid_clean  = !o_last_of_frame && o_error_code == fdfc_pkg::ERR_NONE;
    assign w_held       = !o_empty && !i_pop;

    // An error result always closes its frame with a nonzero code
    `FDFC_ASSERT_NOW(a_error_closes, w_err_shown, w_err_closed)

    // Payload and header results never end a frame or carry an error
    `FDFC_ASSERT_NOW(a_mid_frame_clean, w_mid_shown, w_mid_clean)

    // A result held under stall is not overwritten by the back end
    `FDFC_ASSERT_NEXT(a_result_held, w_held, !o_empty && $stable(o_kind) && $stable(o_payload_len))

endmodule

`default_nettype wire
